// File: rtl/core/lsst_pkg.sv
package lsst_pkg;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_BW_WR  = 2'd1,
      FUNC_PARENT = 2'd2,
      FUNC_COMMIT = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LINK,
      ST_DIV,
      ST_SUM,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  task_index;
      logic [2:0]  target_processor;
      logic [2:0]  source_processor;
      logic [31:0] cost;
      logic [15:0] bandwidth_value;
   } req_type;

   typedef struct packed {
      logic [31:0] earliest_start;
      logic [31:0] finish_time;
      logic [31:0] makespan;
      logic        saturated;
   } rsp_type;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

endpackage

// File: rtl/core/list_schedule_start_time_top.sv
// Earliest-start-time engine for a list scheduler. One transfer in gives one transfer out.
// Items run one at a time: clear and bandwidth write pass READ and OUT, commit passes
// READ, COMMIT and OUT, a parent term READ, LINK, DIV, SUM and OUT. DIV is a radix-2
// restoring divider that produces one quotient bit a cycle over the 40-bit dividend
// (cost << 8); the divide is skipped when the link bandwidth is zero. A finished result
// waits in an output register; while it is not taken the next item stops in its last
// state. Task and bandwidth state sit in synchronous memories with registered reads;
// the bandwidth table is cleared after reset by a pass over all NUM_PROCESSORS**2
// entries, during which no item is taken. Times are unsigned Q24.8 and saturate.
module list_schedule_start_time_top #(
   parameter int NUM_PROCESSORS = 8,
   parameter int NUM_TASKS      = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lsst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lsst_pkg::rsp_type rsp_data
);
   import lsst_pkg::*;

   localparam int PW  = (NUM_PROCESSORS > 1) ? $clog2(NUM_PROCESSORS) : 1;
   localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int BWD = NUM_PROCESSORS * NUM_PROCESSORS;
   localparam int BW  = (BWD > 1) ? $clog2(BWD) : 1;

   // memories
   logic [31:0]   fin_mem [NUM_TASKS];
   logic [PW-1:0] prc_mem [NUM_TASKS];
   logic [15:0]   bw_mem  [BWD];
   logic [31:0]   free_ff [NUM_PROCESSORS];

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff;
   rsp_type   wrk_ff;
   logic        rsp_valid_ff;
   logic [31:0] ready_ff, makespan_ff;
   logic [31:0] fin_rd_ff;
   logic [PW-1:0] prc_rd_ff;
   logic [15:0] bw_rd_ff;
   logic        clr_busy_ff;
   logic [BW:0] clr_cnt_ff;
   logic [39:0] num_ff;
   logic [32:0] rem_ff;
   logic [5:0]  div_cnt_ff;

   // wrapped indices
   logic [PW-1:0] dst, src;
   logic [TW-1:0] tix;
   logic [BW-1:0] bw_wr_addr, bw_rd_addr;

   // index wrap as a constant lookup
   function automatic logic [PW-1:0] wrap_proc(input logic [2:0] v);
      logic [PW-1:0] r;
      r = '0;
      for (int k = 0; k < 8; k++)
         if (v == 3'(k)) r = PW'(k % NUM_PROCESSORS);
      return r;
   endfunction

   function automatic logic [TW-1:0] wrap_task(input logic [7:0] v);
      logic [TW-1:0] r;
      r = '0;
      for (int k = 0; k < 256; k++)
         if (v == 8'(k)) r = TW'(k % NUM_TASKS);
      return r;
   endfunction

   always_comb begin
      dst = wrap_proc(req_ff.target_processor);
      src = wrap_proc(req_ff.source_processor);
      tix = wrap_task(req_ff.task_index);
      bw_wr_addr = BW'(32'(src) * NUM_PROCESSORS + 32'(dst));
      bw_rd_addr = BW'(32'(prc_rd_ff) * NUM_PROCESSORS + 32'(dst));
   end

   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // divider step
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   always_comb begin
      rem_sh  = {rem_ff[31:0], num_ff[39]};
      rem_sub = rem_sh - {17'd0, bw_rd_ff};
   end

   // commit arithmetic
   logic [31:0] cm_start;
   logic [32:0] cm_sum;
   logic [31:0] cm_fin;
   always_comb begin
      cm_start = (free_ff[dst] > ready_ff) ? free_ff[dst] : ready_ff;
      cm_sum   = {1'b0, cm_start} + {1'b0, req_ff.cost};
      cm_fin   = cm_sum[32] ? TIME_MAX : cm_sum[31:0];
   end

   // parent sum; quotient sits in num_ff after the divide
   logic        q_hi;
   logic [32:0] pt_sum;
   always_comb begin
      q_hi   = |num_ff[39:32];
      pt_sum = {1'b0, fin_rd_ff} + {1'b0, (q_hi ? TIME_MAX : num_ff[31:0])};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid && !req_stall) state_in = ST_READ;
         ST_READ: begin
            case (req_ff.func)
               FUNC_PARENT: state_in = ST_LINK;
               FUNC_COMMIT: state_in = ST_COMMIT;
               default:     state_in = ST_OUT;
            endcase
         end
         ST_LINK:   state_in = ST_DIV;
         ST_DIV:    if (bw_rd_ff == 16'd0 || div_cnt_ff == 6'd39) state_in = ST_SUM;
         ST_SUM:    state_in = ST_OUT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) req_ff <= req_data;
      if (state_ff == ST_READ) begin
         fin_rd_ff <= fin_mem[tix];
         prc_rd_ff <= prc_mem[tix];
      end
      if (state_ff == ST_LINK) begin
         bw_rd_ff <= bw_mem[bw_rd_addr];
         num_ff   <= {req_ff.cost, 8'd0};
         rem_ff   <= '0;
      end
      if (state_ff == ST_DIV && bw_rd_ff != 16'd0) begin
         if (!rem_sub[32]) begin
            rem_ff <= rem_sub;
            num_ff <= {num_ff[38:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[38:0], 1'b0};
         end
      end
      if (state_ff == ST_READ && req_ff.func == FUNC_BW_WR)
         bw_mem[bw_wr_addr] <= req_ff.bandwidth_value;
      if (clr_busy_ff) bw_mem[clr_cnt_ff[BW-1:0]] <= 16'd0;
      if (state_ff == ST_COMMIT) begin
         fin_mem[tix] <= cm_fin;
         prc_mem[tix] <= dst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= '0;
         makespan_ff  <= '0;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
         for (int i = 0; i < NUM_PROCESSORS; i++) free_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (BW+1)'(BWD - 1)) clr_busy_ff <= 1'b0;
         end
         // finished item moves to the output register once it is free
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= wrk_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_LINK) div_cnt_ff <= '0;
         if (state_ff == ST_DIV) div_cnt_ff <= div_cnt_ff + 1'b1;
         case (state_ff)
            ST_READ: begin
               if (req_ff.func == FUNC_CLEAR) begin
                  for (int i = 0; i < NUM_PROCESSORS; i++) free_ff[i] <= '0;
                  makespan_ff <= '0;
               end
               wrk_ff.earliest_start <= ready_ff;
               wrk_ff.finish_time    <= '0;
               wrk_ff.saturated      <= 1'b0;
               wrk_ff.makespan       <= (req_ff.func == FUNC_CLEAR) ? '0 : makespan_ff;
            end
            ST_SUM: begin
               if (bw_rd_ff == 16'd0) begin
                  if (fin_rd_ff > ready_ff) ready_ff <= fin_rd_ff;
                  wrk_ff.earliest_start <= (fin_rd_ff > ready_ff) ? fin_rd_ff : ready_ff;
               end else begin
                  if ((pt_sum[32] ? TIME_MAX : pt_sum[31:0]) > ready_ff)
                     ready_ff <= pt_sum[32] ? TIME_MAX : pt_sum[31:0];
                  wrk_ff.earliest_start <=
                     ((pt_sum[32] ? TIME_MAX : pt_sum[31:0]) > ready_ff)
                     ? (pt_sum[32] ? TIME_MAX : pt_sum[31:0]) : ready_ff;
                  wrk_ff.saturated <= q_hi || pt_sum[32];
               end
            end
            ST_COMMIT: begin
               free_ff[dst]          <= cm_fin;
               ready_ff              <= '0;
               if (cm_fin > makespan_ff) makespan_ff <= cm_fin;
               wrk_ff.earliest_start <= cm_start;
               wrk_ff.finish_time    <= cm_fin;
               wrk_ff.makespan       <= (cm_fin > makespan_ff) ? cm_fin : makespan_ff;
               wrk_ff.saturated      <= cm_sum[32];
            end
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/lsst_checker.sv
module lsst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lsst_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lsst_pkg::rsp_type rsp_data
);
   import lsst_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item in flight: accepted transfer blocks further input next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // a nonzero finish time never comes before its start
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finish_time != 32'd0
      |-> rsp_data.earliest_start <= rsp_data.finish_time)
      else $error("finish before start");

   // a commit raises makespan to at least its finish time
   a_mk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.makespan >= rsp_data.finish_time)
      else $error("makespan below finish");

endmodule

bind list_schedule_start_time_top lsst_checker u_lsst_checker (.*);

// File: bench/list_schedule_start_time_checker.sv
`timescale 1ns / 1ps
module list_schedule_start_time_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lsst_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lsst_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import lsst_pkg::*;

   logic [31:0] free_time [8];
   logic [31:0] finish_of [256];
   logic [2:0]  proc_of [256];
   logic [15:0] link_bw [64];
   logic [31:0] ready_max;
   logic [31:0] span;
   rsp_type     timing_queue [$];

   function automatic logic [31:0] clip_add(input logic [31:0] a, input logic [31:0] b,
                                            inout logic clip);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[32]) begin
         clip = 1'b1;
         return TIME_MAX;
      end
      return s[31:0];
   endfunction

   // advances the scheduler state by one item and gives its timing
   function automatic rsp_type schedule_item(input req_type r);
      rsp_type     o;
      logic        clip;
      logic [15:0] bw;
      logic [31:0] term;
      logic [39:0] quot;
      logic [31:0] st;
      logic [31:0] fin;
      clip = 1'b0;
      fin  = '0;
      case (func_type'(r.func))
         FUNC_CLEAR: begin
            foreach (free_time[i]) free_time[i] = '0;
            span = '0;
            st = ready_max;
         end
         FUNC_BW_WR: begin
            link_bw[{r.source_processor, r.target_processor}] = r.bandwidth_value;
            st = ready_max;
         end
         FUNC_PARENT: begin
            bw   = link_bw[{proc_of[r.task_index], r.target_processor}];
            term = finish_of[r.task_index];
            if (bw != 0) begin
               quot = {r.cost, 8'd0} / bw;
               if (quot[39:32] != 0) begin
                  clip = 1'b1;
                  quot = {8'd0, TIME_MAX};
               end
               term = clip_add(term, quot[31:0], clip);
            end
            if (term > ready_max) ready_max = term;
            st = ready_max;
         end
         default: begin
            st = ready_max;
            if (free_time[r.target_processor] > st) st = free_time[r.target_processor];
            fin = clip_add(st, r.cost, clip);
            free_time[r.target_processor] = fin;
            finish_of[r.task_index] = fin;
            proc_of[r.task_index]   = r.target_processor;
            if (fin > span) span = fin;
            ready_max = '0;
         end
      endcase
      o.earliest_start = st;
      o.finish_time    = fin;
      o.makespan       = span;
      o.saturated      = clip;
      return o;
   endfunction

   assign pending_count = timing_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (free_time[i]) free_time[i] <= '0;
         foreach (link_bw[i]) link_bw[i] <= '0;
         ready_max  <= '0;
         span       <= '0;
         fail_count <= 0;
         timing_queue.delete();
      end else begin
         if (req_valid && !req_stall) timing_queue.push_back(schedule_item(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (timing_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = timing_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: start %h/%h finish %h/%h span %h/%h sat %b/%b",
                        want.earliest_start, rsp_data.earliest_start, want.finish_time,
                        rsp_data.finish_time, want.makespan, rsp_data.makespan,
                        want.saturated, rsp_data.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: bench/tb_list_schedule_start_time_top.sv
`timescale 1ns / 1ps
module tb_list_schedule_start_time_top;
   import lsst_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      quiet_phase = 1'b0;
   bit      hold_off = 1'b0;
   bit      committed [256];
   int      committed_list [$];

   always #5 clock = ~clock;

   list_schedule_start_time_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   list_schedule_start_time_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("list_schedule_start_time_top regression: fail");
         $finish;
      end
   end

   // receiver stalls: random bursts, or a long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] rand_cost();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 255);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         2: return $urandom_range(0, 32'h000F_FFFF);
         default: return $urandom();
      endcase
   endfunction

   task automatic send(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.func == FUNC_COMMIT && !committed[r.task_index]) begin
         committed[r.task_index] = 1'b1;
         committed_list.push_back(int'(r.task_index));
      end
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic req_type make_item(input func_type f);
      req_type r;
      r.func             = f;
      r.task_index       = 8'($urandom());
      r.target_processor = 3'($urandom());
      r.source_processor = 3'($urandom());
      r.cost             = rand_cost();
      r.bandwidth_value  = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom());
      if (f == FUNC_PARENT)
         r.task_index = 8'(committed_list[$urandom_range(0, committed_list.size() - 1)]);
      return r;
   endfunction

   // one task: up to three parent terms, then its commit
   task automatic send_task(inout int count);
      int n;
      n = $urandom_range(0, 3);
      repeat (n) send(make_item(FUNC_PARENT));
      send(make_item(FUNC_COMMIT));
      count += n + 1;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      req_type r;
      int sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed part
      r = '0; r.func = FUNC_COMMIT; r.task_index = 8'd0; r.cost = 32'd0;
      send(r);
      r.task_index = 8'hFF; r.target_processor = 3'd7; r.cost = 32'hFFFF_FFFF;
      send(r);
      r = '0; r.func = FUNC_BW_WR; r.source_processor = 3'd7; r.target_processor = 3'd0;
      r.bandwidth_value = 16'd1; send(r);
      r.source_processor = 3'd0; r.target_processor = 3'd7; r.bandwidth_value = 16'hFFFF;
      send(r);
      r = '0; r.func = FUNC_PARENT; r.task_index = 8'hFF; r.target_processor = 3'd0;
      r.cost = 32'hFFFF_FFFF; send(r);
      r.task_index = 8'd0; r.target_processor = 3'd7; r.cost = 32'h1234_5678; send(r);
      r.target_processor = 3'd3; send(r);
      r = '0; r.func = FUNC_COMMIT; r.task_index = 8'd5; r.target_processor = 3'd2;
      r.cost = 32'h100; send(r);
      r = '0; r.func = FUNC_CLEAR; r.task_index = 8'hFF; r.cost = 32'hFFFF_FFFF;
      r.bandwidth_value = 16'hFFFF; r.target_processor = 3'd7; r.source_processor = 3'd7;
      send(r);
      r = '0; r.func = FUNC_PARENT; r.task_index = 8'd5; send(r);
      send(make_item(FUNC_CLEAR));
      r = '0; r.func = FUNC_COMMIT; r.task_index = 8'd6; r.target_processor = 3'd2;
      send(r);
      drain();
      // sender pauses until everything is back, and receiver holds off
      hold_off = 1'b1;
      for (int i = 0; i < 64; i++) begin
         r = make_item(FUNC_BW_WR);
         r.source_processor = i[5:3]; r.target_processor = i[2:0];
         send(r);
      end
      drain();
      sent = 76;
      while (sent < 1650) begin
         if (sent > 1450) quiet_phase = 1'b1;
         case ($urandom_range(0, 19))
            0: begin send(make_item(FUNC_CLEAR)); sent++; end
            1, 2: begin send(make_item(FUNC_BW_WR)); sent++; end
            3: begin
               r = make_item(FUNC_PARENT);
               r.func = 2'($urandom_range(0, 3));
               if (r.func == FUNC_BW_WR) r.func = FUNC_COMMIT;
               send(r); sent++;
            end
            default: send_task(sent);
         endcase
      end
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("list_schedule_start_time_top regression: pass");
      else
         $display("list_schedule_start_time_top regression: fail");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/lsst_pkg.sv
rtl/core/list_schedule_start_time_top.sv
rtl/core/lsst_checker.sv
bench/list_schedule_start_time_checker.sv
bench/tb_list_schedule_start_time_top.sv
